[rtl/tiapc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tank and irrigation pump controller package
// Shared widths, register indexes, run state codes and timing constants.
// ----------------------------------------------------------------------------
package tiapc_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned LEVEL_W  = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned FILL_LIM_W = 24;
  localparam int unsigned IRR_LIM_W  = 26;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TANK_HIGH   = 3'd0,
    CFG_TANK_LOW    = 3'd1,
    CFG_FILL_MAXMIN = 3'd2,
    CFG_IRR_RUN     = 3'd3,
    CFG_IRR_PAUSE   = 3'd4
  } cfg_idx_t;

  // Reported run state codes.
  typedef enum logic [3:0] {
    ST_STARTING     = 4'd0,
    ST_IDLE         = 4'd1,
    ST_FILLING      = 4'd2,
    ST_TANK_LOW     = 4'd3,
    ST_IRRIGATING   = 4'd4,
    ST_PAUSE        = 4'd5,
    ST_SENSOR_FAULT = 4'd6,
    ST_TIMEOUT      = 4'd7,
    ST_BATTERY_LOW  = 4'd8
  } run_state_t;

  localparam logic [TIME_W-1:0]     ALERT_INTERVAL_MS = 32'd2000;
  localparam logic [FILL_LIM_W-1:0] MS_PER_MINUTE     = 24'd60000;
  localparam logic [IRR_LIM_W-1:0]  MS_PER_SECOND     = 26'd1000;

  // Register reset values.
  localparam logic [LEVEL_W-1:0]    TANK_HIGH_RST   = 7'd90;
  localparam logic [LEVEL_W-1:0]    TANK_LOW_RST    = 7'd20;
  localparam logic [FILL_LIM_W-1:0] FILL_LIM_RST    = 24'd600000;
  localparam logic [IRR_LIM_W-1:0]  RUN_LIM_RST     = 26'd60000;
  localparam logic [IRR_LIM_W-1:0]  PAUSE_LIM_RST   = 26'd300000;

endpackage

[rtl/tiapc_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tank and irrigation pump controller tick channel
// Valid/ready channel carrying one control tick per transaction.
// ----------------------------------------------------------------------------
interface tiapc_in_if import tiapc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TIME_W-1:0]  now_ms;
  logic [LEVEL_W-1:0] level_percent;
  logic               level_sensor_ready;
  logic               level_sensor_error;
  logic               batt_low;
  logic               soil_ready;
  logic               soil_dry;

  modport source (
    output valid, now_ms, level_percent, level_sensor_ready, level_sensor_error,
           batt_low, soil_ready, soil_dry,
    input  ready
  );
  modport sink (
    input  valid, now_ms, level_percent, level_sensor_ready, level_sensor_error,
           batt_low, soil_ready, soil_dry,
    output ready
  );
endinterface

[rtl/tiapc_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tank and irrigation pump controller result channel
// Valid/ready channel carrying one pump decision per transaction.
// ----------------------------------------------------------------------------
interface tiapc_out_if;
  logic       valid;
  logic       ready;
  logic       tank_pump_on;
  logic       irrigation_pump_on;
  logic [3:0] run_state;
  logic       beep_request;
  logic       fault;

  modport source (
    output valid, tank_pump_on, irrigation_pump_on, run_state, beep_request, fault,
    input  ready
  );
  modport sink (
    input  valid, tank_pump_on, irrigation_pump_on, run_state, beep_request, fault,
    output ready
  );
endinterface

[rtl/tank_and_irrigation_pump_controller_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tank and irrigation pump controller core
// Fill pump hysteresis with timeout, irrigation run/pause cycling, run state
// reporting and rate-limited alarm beep requests.
// ----------------------------------------------------------------------------
// Usage:
// Each transaction on in_ch is one control tick carrying a millisecond
// timestamp and the sensor flags. Every tick produces exactly one
// transaction on out_ch with both pump drive bits, the run state, a beep
// request (the buzzer is expected to sound for 150 ms) and a fault flag.
// A tick is captured in an input register; when the result register can
// advance, the decision logic updates the controller state and loads the
// result register from that tick. One tick per cycle is sustained while
// the receiver does not stall; the rate is set by the update of the
// controller state, which each tick reads and writes.
// When the receiver stalls, the result register holds and the input
// register holds the next tick; in_ch.ready drops only when both are full.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while the
// block is idle; the millisecond limits are multiplied out at write time.
// Writes to an index beyond the register list are ignored.
// Reset (rst_n low, synchronous) empties both registers, restores the
// register defaults and puts the controller into the starting state with
// both pumps off and all timestamps at zero.
// ----------------------------------------------------------------------------
module tank_and_irrigation_pump_controller_core import tiapc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  tiapc_in_if.sink              in_ch,
  tiapc_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration, with the timeouts already scaled to milliseconds.
  logic [LEVEL_W-1:0]    tank_high_r;
  logic [LEVEL_W-1:0]    tank_low_r;
  logic [FILL_LIM_W-1:0] fill_lim_r;
  logic [IRR_LIM_W-1:0]  run_lim_r;
  logic [IRR_LIM_W-1:0]  pause_lim_r;

  // Input register.
  logic               s1_valid_r;
  logic [TIME_W-1:0]  s1_now_r;
  logic [LEVEL_W-1:0] s1_level_r;
  logic               s1_lvl_rdy_r;
  logic               s1_lvl_err_r;
  logic               s1_batt_r;
  logic               s1_soil_rdy_r;
  logic               s1_dry_r;

  // Controller state.
  logic              fill_active_r, fill_active_nxt;
  logic              irr_running_r, irr_running_nxt;
  logic              irr_paused_r, irr_paused_nxt;
  logic              fill_fault_r, fill_fault_nxt;
  logic [TIME_W-1:0] fill_start_r, fill_start_nxt;
  logic [TIME_W-1:0] irr_start_r, irr_start_nxt;
  logic [TIME_W-1:0] pause_start_r, pause_start_nxt;
  logic [TIME_W-1:0] last_alert_r, last_alert_nxt;
  run_state_t        mode_r, mode_nxt;
  logic              tank_bit_r, tank_bit_nxt;
  logic              irr_bit_r, irr_bit_nxt;
  logic              beep_nxt;

  // Result register; the run state is reported straight from mode_r.
  logic       out_valid_r;
  logic       out_tank_r;
  logic       out_irr_r;
  logic       out_beep_r;
  logic       out_fault_r;

  logic advance;
  logic in_take;

  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  assign out_ch.valid              = out_valid_r;
  assign out_ch.tank_pump_on       = out_tank_r;
  assign out_ch.irrigation_pump_on = out_irr_r;
  assign out_ch.run_state          = mode_r;
  assign out_ch.beep_request       = out_beep_r;
  assign out_ch.fault              = out_fault_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tank_high_r <= TANK_HIGH_RST;
      tank_low_r  <= TANK_LOW_RST;
      fill_lim_r  <= FILL_LIM_RST;
      run_lim_r   <= RUN_LIM_RST;
      pause_lim_r <= PAUSE_LIM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TANK_HIGH:   tank_high_r <= cfg_wdata[LEVEL_W-1:0];
        CFG_TANK_LOW:    tank_low_r  <= cfg_wdata[LEVEL_W-1:0];
        CFG_FILL_MAXMIN: fill_lim_r  <= FILL_LIM_W'(cfg_wdata[7:0]) * MS_PER_MINUTE;
        CFG_IRR_RUN:     run_lim_r   <= IRR_LIM_W'(cfg_wdata) * MS_PER_SECOND;
        CFG_IRR_PAUSE:   pause_lim_r <= IRR_LIM_W'(cfg_wdata) * MS_PER_SECOND;
        default: ;
      endcase
    end
  end

  // Decision logic for the tick held in the input register.
  always_comb begin
    logic [TIME_W-1:0] fill_el, irr_el, pause_el, alert_el;
    logic              at_high, at_low, allowed, alarm;

    fill_active_nxt = fill_active_r;
    irr_running_nxt = irr_running_r;
    irr_paused_nxt  = irr_paused_r;
    fill_fault_nxt  = fill_fault_r;
    fill_start_nxt  = fill_start_r;
    irr_start_nxt   = irr_start_r;
    pause_start_nxt = pause_start_r;
    tank_bit_nxt    = tank_bit_r;
    irr_bit_nxt     = irr_bit_r;
    mode_nxt        = ST_IDLE;
    alarm           = 1'b0;
    fill_el         = '0;
    irr_el          = '0;
    pause_el        = '0;
    allowed         = 1'b0;

    at_high = s1_level_r >= tank_high_r;
    at_low  = s1_level_r <= tank_low_r;

    if (!s1_lvl_rdy_r) begin
      // Sensor not ready: pumps off, sequencing flags kept.
      tank_bit_nxt = 1'b0;
      irr_bit_nxt  = 1'b0;
      mode_nxt     = ST_SENSOR_FAULT;
      alarm        = s1_lvl_err_r;
    end else if (s1_batt_r) begin
      tank_bit_nxt    = 1'b0;
      fill_active_nxt = 1'b0;
      irr_running_nxt = 1'b0;
      irr_paused_nxt  = 1'b0;
      irr_bit_nxt     = 1'b0;
      mode_nxt        = fill_fault_r ? ST_TIMEOUT : ST_BATTERY_LOW;
      alarm           = 1'b1;
    end else begin
      // Tank fill pump.
      if (at_high) begin
        fill_active_nxt = 1'b0;
        fill_fault_nxt  = 1'b0;
        tank_bit_nxt    = 1'b0;
      end else begin
        if (at_low && !fill_fault_r && !fill_active_r) begin
          fill_active_nxt = 1'b1;
          fill_start_nxt  = s1_now_r;
        end
        fill_el = s1_now_r - fill_start_nxt;
        if (fill_active_nxt) begin
          if ((fill_lim_r != '0) && (fill_el >= TIME_W'(fill_lim_r))) begin
            fill_active_nxt = 1'b0;
            fill_fault_nxt  = 1'b1;
            tank_bit_nxt    = 1'b0;
          end else begin
            tank_bit_nxt = 1'b1;
          end
        end else begin
          tank_bit_nxt = 1'b0;
        end
      end

      // Irrigation run/pause cycle.
      allowed = !at_low && !fill_fault_nxt && s1_soil_rdy_r;
      if (!allowed || !s1_dry_r) begin
        irr_running_nxt = 1'b0;
        irr_paused_nxt  = 1'b0;
        irr_bit_nxt     = 1'b0;
      end else begin
        if (!irr_running_r && !irr_paused_r) begin
          irr_running_nxt = 1'b1;
          irr_start_nxt   = s1_now_r;
          irr_bit_nxt     = 1'b1;
        end
        irr_el = s1_now_r - irr_start_nxt;
        if (irr_running_nxt && (irr_el >= TIME_W'(run_lim_r))) begin
          irr_running_nxt = 1'b0;
          irr_paused_nxt  = 1'b1;
          pause_start_nxt = s1_now_r;
          irr_bit_nxt     = 1'b0;
        end
        pause_el = s1_now_r - pause_start_nxt;
        if (irr_paused_nxt && (pause_el >= TIME_W'(pause_lim_r))) begin
          irr_paused_nxt = 1'b0;
        end
      end

      if (fill_fault_nxt)       mode_nxt = ST_TIMEOUT;
      else if (at_low)          mode_nxt = ST_TANK_LOW;
      else if (fill_active_nxt) mode_nxt = ST_FILLING;
      else if (irr_running_nxt) mode_nxt = ST_IRRIGATING;
      else if (irr_paused_nxt)  mode_nxt = ST_PAUSE;
      else                      mode_nxt = ST_IDLE;
      alarm = (mode_nxt == ST_TIMEOUT) || (mode_nxt == ST_TANK_LOW);
    end

    // Beep at most once per alert interval while an alarm is active.
    alert_el       = s1_now_r - last_alert_r;
    beep_nxt       = alarm && (alert_el >= ALERT_INTERVAL_MS);
    last_alert_nxt = beep_nxt ? s1_now_r : last_alert_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      fill_active_r <= 1'b0;
      irr_running_r <= 1'b0;
      irr_paused_r  <= 1'b0;
      fill_fault_r  <= 1'b0;
      fill_start_r  <= '0;
      irr_start_r   <= '0;
      pause_start_r <= '0;
      last_alert_r  <= '0;
      mode_r        <= ST_STARTING;
      tank_bit_r    <= 1'b0;
      irr_bit_r     <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (advance && s1_valid_r) begin
        fill_active_r <= fill_active_nxt;
        irr_running_r <= irr_running_nxt;
        irr_paused_r  <= irr_paused_nxt;
        fill_fault_r  <= fill_fault_nxt;
        fill_start_r  <= fill_start_nxt;
        irr_start_r   <= irr_start_nxt;
        pause_start_r <= pause_start_nxt;
        last_alert_r  <= last_alert_nxt;
        mode_r        <= mode_nxt;
        tank_bit_r    <= tank_bit_nxt;
        irr_bit_r     <= irr_bit_nxt;
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_now_r      <= in_ch.now_ms;
      s1_level_r    <= in_ch.level_percent;
      s1_lvl_rdy_r  <= in_ch.level_sensor_ready;
      s1_lvl_err_r  <= in_ch.level_sensor_error;
      s1_batt_r     <= in_ch.batt_low;
      s1_soil_rdy_r <= in_ch.soil_ready;
      s1_dry_r      <= in_ch.soil_dry;
    end
    if (advance && s1_valid_r) begin
      out_tank_r  <= tank_bit_nxt;
      out_irr_r   <= irr_bit_nxt;
      out_beep_r  <= beep_nxt;
      out_fault_r <= (mode_nxt == ST_SENSOR_FAULT) || (mode_nxt == ST_TIMEOUT);
    end
  end

  // The fill pump is never driven while the timeout fault is latched.
  assert property (@(posedge clk) disable iff (!rst_n) fill_fault_r |-> !tank_bit_r)
    else $error("tank pump on with fill timeout latched");

  // The irrigation cycle is in at most one phase at a time.
  assert property (@(posedge clk) disable iff (!rst_n) !(irr_running_r && irr_paused_r))
    else $error("irrigation running and paused together");

  // The irrigation pump only runs inside a run phase.
  assert property (@(posedge clk) disable iff (!rst_n) irr_bit_r |-> irr_running_r)
    else $error("irrigation pump on outside a run phase");

  // A held tick is not lost while the result register is stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_now_r)))
    else $error("input register lost a tick during a stall");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the tank and irrigation pump controller core
// Drives control ticks through the valid/ready input channel and checks
// every result transaction, field by field, against a behavioural predictor
// of fill hysteresis and timeout, irrigation run/pause cycling, run state
// priority and alarm beep rate limit, or a pinned row's typed value. A short
// directed table comes first, then random phases with new settings and idling.
// ----------------------------------------------------------------------------
module tb_top;
  import tiapc_pkg::*;

  localparam int CLK_HALF_NS   = 10;
  localparam int RESET_CYCLES  = 10;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 325;
  localparam int DIR_N         = 25;
  localparam int LEVEL_MAX     = (1 << LEVEL_W) - 1;

  // An index past the register list; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd5;

  // Per-phase idling, in percent of cycles: none, sender, receiver, both, none, both.
  localparam int PHASE_SEND_IDLE [PHASES] = '{0, 65, 0, 30, 0, 30};
  localparam int PHASE_RECV_STALL[PHASES] = '{0, 0, 65, 30, 0, 30};

  typedef struct packed {
    logic [TIME_W-1:0]  now_ms;
    logic [LEVEL_W-1:0] level;
    logic               sensor_ready;
    logic               sensor_error;
    logic               batt_low;
    logic               soil_ready;
    logic               soil_dry;
  } tick_t;

  typedef struct packed {
    logic       tank_on;
    logic       irr_on;
    run_state_t state;
    logic       beep;
    logic       fault;
  } decision_t;

  // A stimulus row: the tick, plus an expected decision typed in by hand
  // where it can be read straight off the behaviour (pinned rows).
  typedef struct packed {
    tick_t     tick;
    logic      pinned;
    decision_t want;
  } row_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] high;
    logic [CFG_DATA_W-1:0] low;
    logic [CFG_DATA_W-1:0] fill_min;
    logic [CFG_DATA_W-1:0] run_s;
    logic [CFG_DATA_W-1:0] pause_s;
  } reg_set_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tiapc_in_if  in_ch ();
  tiapc_out_if out_ch ();

  tank_and_irrigation_pump_controller_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Register shadow, starting from the reset values.
  logic [LEVEL_W-1:0] lvl_high     = TANK_HIGH_RST;
  logic [LEVEL_W-1:0] lvl_low      = TANK_LOW_RST;
  logic [7:0]         fill_max_min = 8'd10;
  logic [15:0]        run_secs     = 16'd60;
  logic [15:0]        rest_secs    = 16'd300;

  // Controller state as the predictor sees it; everything is zero at reset.
  logic              fill_running = 1'b0;
  logic              irr_running  = 1'b0;
  logic              irr_resting  = 1'b0;
  logic              fill_fault   = 1'b0;
  logic [TIME_W-1:0] fill_t0      = '0;
  logic [TIME_W-1:0] irr_t0       = '0;
  logic [TIME_W-1:0] rest_t0      = '0;
  logic [TIME_W-1:0] beep_t0      = '0;
  run_state_t        mode_now     = ST_STARTING;
  logic              tank_drive   = 1'b0;
  logic              irr_drive    = 1'b0;

  row_t      ticks_in_flight[$];
  decision_t due_decisions[$];
  int        mismatches  = 0;
  int        send_idle   = 0;
  int        recv_stall  = 0;
  int unsigned cycle_count = 0;

  function automatic row_t mk_row(input logic [TIME_W-1:0] now, input int lvl,
                                  input bit rdy, err, batt, srdy, dry,
                                  input bit pin, tank, irr, input run_state_t st,
                                  input bit bp, flt);
    row_t r;
    r.tick.now_ms       = now;
    r.tick.level        = LEVEL_W'(lvl);
    r.tick.sensor_ready = rdy;
    r.tick.sensor_error = err;
    r.tick.batt_low     = batt;
    r.tick.soil_ready   = srdy;
    r.tick.soil_dry     = dry;
    r.pinned            = pin;
    r.want.tank_on      = tank;
    r.want.irr_on       = irr;
    r.want.state        = st;
    r.want.beep         = bp;
    r.want.fault        = flt;
    return r;
  endfunction

  // Directed table, walked at the reset register values (high 90 %, low 20 %,
  // 10 minute fill limit, 60 s run, 300 s pause). Columns: time, level,
  // sensor ready, sensor error, battery low, soil ready, soil dry, pinned,
  // then the pinned tank, irrigation, state, beep and fault.
  row_t directed_rows [DIR_N] = '{
    // Quiet start: mid level, soil wet.
    mk_row(0,       50,  1, 0, 0, 1, 0, 1, 0, 0, ST_IDLE,         0, 0),
    // Empty tank starts filling; the first alarm cannot beep before 2000 ms.
    mk_row(100,     0,   1, 0, 0, 1, 1, 1, 1, 0, ST_TANK_LOW,     0, 0),
    mk_row(2000,    0,   1, 0, 0, 1, 1, 1, 1, 0, ST_TANK_LOW,     1, 0),
    mk_row(3000,    0,   1, 0, 0, 1, 1, 1, 1, 0, ST_TANK_LOW,     0, 0),
    // Ten minutes of filling without reaching the top latches the timeout.
    mk_row(600100,  10,  1, 0, 0, 1, 1, 1, 0, 0, ST_TIMEOUT,      1, 1),
    mk_row(600200,  50,  1, 0, 0, 1, 1, 1, 0, 0, ST_TIMEOUT,      0, 1),
    // A level past 100 % counts as high, clears the fault and lets the
    // irrigation cycle start.
    mk_row(601000,  127, 1, 0, 0, 1, 1, 1, 0, 1, ST_IRRIGATING,   0, 0),
    mk_row(661000,  127, 1, 0, 0, 1, 1, 1, 0, 0, ST_PAUSE,        0, 0),
    mk_row(961000,  100, 1, 0, 0, 1, 1, 1, 0, 0, ST_IDLE,         0, 0),
    mk_row(962000,  100, 1, 0, 0, 1, 1, 1, 0, 1, ST_IRRIGATING,   0, 0),
    // Sensor drop-out mid run: pumps off, the run flag survives, and the
    // pump stays off afterwards until a new run begins.
    mk_row(963000,  100, 0, 1, 0, 1, 1, 1, 0, 0, ST_SENSOR_FAULT, 1, 1),
    mk_row(963500,  100, 1, 0, 0, 1, 1, 1, 0, 0, ST_IRRIGATING,   0, 0),
    mk_row(970000,  100, 0, 0, 0, 1, 1, 1, 0, 0, ST_SENSOR_FAULT, 0, 1),
    // Low battery forces everything off and beeps at most every 2000 ms.
    mk_row(971000,  100, 1, 0, 1, 1, 1, 1, 0, 0, ST_BATTERY_LOW,  1, 0),
    mk_row(972000,  100, 1, 0, 1, 1, 1, 1, 0, 0, ST_BATTERY_LOW,  0, 0),
    mk_row(973000,  100, 1, 0, 0, 0, 1, 1, 0, 0, ST_IDLE,         0, 0),
    // A run that spans the wrap of the millisecond counter.
    mk_row(32'hFFFF_FF00, 50, 1, 0, 0, 1, 1, 1, 0, 1, ST_IRRIGATING, 0, 0),
    mk_row(32'h0000_E960, 50, 1, 0, 0, 1, 1, 1, 0, 0, ST_PAUSE,      0, 0),
    // Timeout again, then battery low while it is latched, a sensor error, then
    // the exact threshold levels.
    mk_row(60744,   5,   1, 0, 0, 1, 0, 0, 0, 0, ST_STARTING,     0, 0),
    mk_row(660744,  5,   1, 0, 0, 1, 0, 0, 0, 0, ST_STARTING,     0, 0),
    mk_row(661000,  5,   1, 0, 1, 1, 0, 0, 0, 0, ST_STARTING,     0, 0),
    mk_row(662000,  0,   0, 1, 0, 1, 0, 0, 0, 0, ST_STARTING,     0, 0),
    mk_row(670000,  90,  1, 0, 0, 1, 0, 0, 0, 0, ST_STARTING,     0, 0),
    mk_row(671000,  20,  1, 0, 0, 1, 1, 0, 0, 0, ST_STARTING,     0, 0),
    mk_row(672000,  21,  1, 0, 0, 1, 1, 0, 0, 0, ST_STARTING,     0, 0)
  };

  // Predictor: advances the controller state by one tick and works out the
  // decision that the block should report for it.
  task automatic decide_tick(input tick_t t, output decision_t d);
    logic [TIME_W-1:0] fill_limit;
    logic [TIME_W-1:0] run_limit;
    logic [TIME_W-1:0] rest_limit;
    logic              allowed;
    logic              alarm;
    fill_limit = 32'(fill_max_min) * 32'(MS_PER_MINUTE);
    run_limit  = 32'(run_secs) * 32'(MS_PER_SECOND);
    rest_limit = 32'(rest_secs) * 32'(MS_PER_SECOND);
    if (!t.sensor_ready) begin
      // Pumps off, but the fill and irrigation flags are kept as they are.
      tank_drive = 1'b0;
      irr_drive  = 1'b0;
      mode_now   = ST_SENSOR_FAULT;
      alarm      = t.sensor_error;
    end else if (t.batt_low) begin
      tank_drive   = 1'b0;
      fill_running = 1'b0;
      irr_running  = 1'b0;
      irr_resting  = 1'b0;
      irr_drive    = 1'b0;
      mode_now     = fill_fault ? ST_TIMEOUT : ST_BATTERY_LOW;
      alarm        = 1'b1;
    end else begin
      // Tank fill with hysteresis and a run-time limit.
      if (t.level >= lvl_high) begin
        fill_running = 1'b0;
        fill_fault   = 1'b0;
        tank_drive   = 1'b0;
      end else begin
        if (t.level <= lvl_low && !fill_fault && !fill_running) begin
          fill_running = 1'b1;
          fill_t0      = t.now_ms;
        end
        if (fill_running && fill_limit != '0 && t.now_ms - fill_t0 >= fill_limit) begin
          fill_running = 1'b0;
          fill_fault   = 1'b1;
          tank_drive   = 1'b0;
        end else begin
          tank_drive = fill_running;
        end
      end
      // Irrigation run/pause cycling while the soil is dry.
      allowed = t.level > lvl_low && !fill_fault && t.soil_ready;
      if (!allowed || !t.soil_dry) begin
        irr_running = 1'b0;
        irr_resting = 1'b0;
        irr_drive   = 1'b0;
      end else begin
        if (!irr_running && !irr_resting) begin
          irr_running = 1'b1;
          irr_t0      = t.now_ms;
          irr_drive   = 1'b1;
        end
        if (irr_running && t.now_ms - irr_t0 >= run_limit) begin
          irr_running = 1'b0;
          irr_resting = 1'b1;
          rest_t0     = t.now_ms;
          irr_drive   = 1'b0;
        end
        if (irr_resting && t.now_ms - rest_t0 >= rest_limit) begin
          irr_resting = 1'b0;
        end
      end
      if (fill_fault) begin
        mode_now = ST_TIMEOUT;
      end else if (t.level <= lvl_low) begin
        mode_now = ST_TANK_LOW;
      end else if (fill_running) begin
        mode_now = ST_FILLING;
      end else if (irr_running) begin
        mode_now = ST_IRRIGATING;
      end else if (irr_resting) begin
        mode_now = ST_PAUSE;
      end else begin
        mode_now = ST_IDLE;
      end
      // With the sensor ready and the battery fine, only these two alarm
      // states can arise here.
      alarm = (mode_now == ST_TANK_LOW) || (mode_now == ST_TIMEOUT);
    end
    d.beep = 1'b0;
    if (alarm && t.now_ms - beep_t0 >= ALERT_INTERVAL_MS) begin
      beep_t0 = t.now_ms;
      d.beep  = 1'b1;
    end
    d.tank_on = tank_drive;
    d.irr_on  = irr_drive;
    d.state   = mode_now;
    d.fault   = (mode_now == ST_SENSOR_FAULT) || (mode_now == ST_TIMEOUT);
  endtask

  // Offers one tick on the input channel, idling first at the sender's rate,
  // and returns at the edge where the transaction is taken.
  task automatic send_tick(input row_t r);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    ticks_in_flight.push_back(r);
    in_ch.valid              <= 1'b1;
    in_ch.now_ms             <= r.tick.now_ms;
    in_ch.level_percent      <= r.tick.level;
    in_ch.level_sensor_ready <= r.tick.sensor_ready;
    in_ch.level_sensor_error <= r.tick.sensor_error;
    in_ch.batt_low           <= r.tick.batt_low;
    in_ch.soil_ready         <= r.tick.soil_ready;
    in_ch.soil_dry           <= r.tick.soil_dry;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Waits until every expected decision has come back, then lets the
  // pipeline settle. The caller has already dropped valid.
  task automatic drain();
    @(posedge clk);
    while (due_decisions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all five registers, plus one write to an unused index, on
  // consecutive cycles while the block is idle.
  task automatic program_regs(input reg_set_t c);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TANK_HIGH;
    cfg_wdata <= c.high;
    @(posedge clk);
    cfg_index <= CFG_TANK_LOW;
    cfg_wdata <= c.low;
    @(posedge clk);
    cfg_index <= CFG_FILL_MAXMIN;
    cfg_wdata <= c.fill_min;
    @(posedge clk);
    cfg_index <= CFG_IRR_RUN;
    cfg_wdata <= c.run_s;
    @(posedge clk);
    cfg_index <= CFG_IRR_PAUSE;
    cfg_wdata <= c.pause_s;
    @(posedge clk);
    cfg_index <= CFG_UNUSED_IDX;
    cfg_wdata <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #CLK_HALF_NS clk = ~clk;
  end

  // Receiver: back-pressure at the rate of the current phase.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL tank_and_irrigation_pump_controller_core");
      $finish;
    end
  end

  // Monitor. Register writes update the shadow, each accepted tick is run
  // through the predictor, and each accepted result is checked against the
  // oldest expected decision. Pinned rows replace the prediction with the
  // hand-typed value, though the predictor still steps its state.
  always @(posedge clk) begin
    tick_t     seen;
    row_t      sent;
    decision_t model_out;
    decision_t want;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TANK_HIGH:   lvl_high     = cfg_wdata[LEVEL_W-1:0];
          CFG_TANK_LOW:    lvl_low      = cfg_wdata[LEVEL_W-1:0];
          CFG_FILL_MAXMIN: fill_max_min = cfg_wdata[7:0];
          CFG_IRR_RUN:     run_secs     = cfg_wdata;
          CFG_IRR_PAUSE:   rest_secs    = cfg_wdata;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        seen.now_ms       = in_ch.now_ms;
        seen.level        = in_ch.level_percent;
        seen.sensor_ready = in_ch.level_sensor_ready;
        seen.sensor_error = in_ch.level_sensor_error;
        seen.batt_low     = in_ch.batt_low;
        seen.soil_ready   = in_ch.soil_ready;
        seen.soil_dry     = in_ch.soil_dry;
        decide_tick(seen, model_out);
        sent = (ticks_in_flight.size() != 0) ? ticks_in_flight.pop_front() : '0;
        due_decisions.push_back(sent.pinned ? sent.want : model_out);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (due_decisions.size() == 0) begin
          $error("result transaction with no tick outstanding");
          mismatches++;
        end else begin
          want = due_decisions.pop_front();
          if (out_ch.tank_pump_on !== want.tank_on) begin
            $error("tank_pump_on: expected %0b, got %0b", want.tank_on, out_ch.tank_pump_on);
            mismatches++;
          end
          if (out_ch.irrigation_pump_on !== want.irr_on) begin
            $error("irrigation_pump_on: expected %0b, got %0b",
                   want.irr_on, out_ch.irrigation_pump_on);
            mismatches++;
          end
          if (out_ch.run_state !== want.state) begin
            $error("run_state: expected %0d, got %0d", want.state, out_ch.run_state);
            mismatches++;
          end
          if (out_ch.beep_request !== want.beep) begin
            $error("beep_request: expected %0b, got %0b", want.beep, out_ch.beep_request);
            mismatches++;
          end
          if (out_ch.fault !== want.fault) begin
            $error("fault: expected %0b, got %0b", want.fault, out_ch.fault);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    row_t              r;
    reg_set_t          c;
    logic [TIME_W-1:0] clock_ms;
    int                lvl;
    int                trend;
    int                sel;
    logic              dry;

    rst_n                    <= 1'b0;
    cfg_we                   <= 1'b0;
    cfg_index                <= CFG_TANK_HIGH;
    cfg_wdata                <= '0;
    in_ch.valid              <= 1'b0;
    in_ch.now_ms             <= '0;
    in_ch.level_percent      <= '0;
    in_ch.level_sensor_ready <= 1'b0;
    in_ch.level_sensor_error <= 1'b0;
    in_ch.batt_low           <= 1'b0;
    in_ch.soil_ready         <= 1'b0;
    in_ch.soil_dry           <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table at the reset register values, back to back.
    foreach (directed_rows[i]) send_tick(directed_rows[i]);
    in_ch.valid <= 1'b0;
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        // Short limits so that runs, pauses and timeouts come round often.
        0: c = '{16'd60, 16'd30, 16'd1, 16'd2, 16'd3};
        // All zero: tank never fills, runs and pauses end as they begin.
        1: c = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
        // All ones: the narrow registers keep only their low bits.
        2: c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        default: begin
          c.high     = CFG_DATA_W'($urandom_range(100, 40));
          c.low      = CFG_DATA_W'($urandom_range(40));
          c.fill_min = CFG_DATA_W'($urandom_range(2));
          c.run_s    = CFG_DATA_W'($urandom_range(8));
          c.pause_s  = CFG_DATA_W'($urandom_range(8));
        end
      endcase
      program_regs(c);
      send_idle  = PHASE_SEND_IDLE[p];
      recv_stall = PHASE_RECV_STALL[p];
      clock_ms   = $urandom;
      lvl        = $urandom_range(LEVEL_MAX);
      trend      = 1;
      dry        = 1'b1;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Half way through, hold off until every decision has come back.
        if (n == PHASE_ITEMS / 2) begin
          in_ch.valid <= 1'b0;
          drain();
        end
        // Mostly small time steps, some long gaps and the odd jump anywhere.
        sel = $urandom_range(99);
        if (sel < 70) begin
          clock_ms += $urandom_range(1500);
        end else if (sel < 90) begin
          clock_ms += $urandom_range(20000);
        end else if (sel < 97) begin
          clock_ms += $urandom_range(200000);
        end else begin
          clock_ms = $urandom;
        end
        // The level drifts in one direction for a while so that both the
        // low and high thresholds are crossed, with occasional jumps.
        if ($urandom_range(99) < 4) trend = -trend;
        lvl = lvl + trend * int'($urandom_range(3)) + int'($urandom_range(2)) - 1;
        if ($urandom_range(99) < 3) lvl = $urandom_range(LEVEL_MAX);
        if (lvl < 0) lvl = 0;
        if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
        if ($urandom_range(99) < 10) dry = !dry;
        r = mk_row(clock_ms, lvl, $urandom_range(99) >= 8, $urandom_range(1),
                   $urandom_range(99) < 5, $urandom_range(99) >= 8, dry,
                   1'b0, 1'b0, 1'b0, ST_STARTING, 1'b0, 1'b0);
        send_tick(r);
      end
      in_ch.valid <= 1'b0;
      drain();
    end

    if (mismatches == 0) begin
      $display("PASS tank_and_irrigation_pump_controller_core");
    end else begin
      $display("FAIL tank_and_irrigation_pump_controller_core");
    end
    $finish;
  end

endmodule
